// ===== hdl/midi_short_message_parser_assert.svh =====
// Assertion macros for the MIDI short message parser checker.
// Used by msmp_checker.sv; needs clk and arst_n in the including scope.
`ifndef MIDI_SHORT_MESSAGE_PARSER_ASSERT_SVH
`define MIDI_SHORT_MESSAGE_PARSER_ASSERT_SVH

// same-cycle implication
`define MSMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/msmp_pkg.sv =====
// Package for the MIDI short message parser: widths, status codes,
// transaction payload types and the message length decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msmp_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned DATA_W    = 7;
	localparam int unsigned ARRIVAL_W = 63;
	localparam int unsigned DELAY_W   = 32;
	localparam int unsigned TIME_W    = 42;
	localparam int unsigned TIME_LSB  = 10;
	localparam int unsigned SUM_W     = TIME_W + TIME_LSB;
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd600000;

	// register word index, taken from paddr[PADDR_W-1]
	localparam logic REG_DELAY = 1'b0;

	localparam logic [BYTE_W-1:0] ST_NONE      = 8'h00;
	localparam logic [BYTE_W-1:0] ST_SYSEX     = 8'hF0;
	localparam logic [BYTE_W-1:0] ST_MTC       = 8'hF1;
	localparam logic [BYTE_W-1:0] ST_SONG_POS  = 8'hF2;
	localparam logic [BYTE_W-1:0] ST_SONG_SEL  = 8'hF3;
	localparam logic [BYTE_W-1:0] ST_UNDEF_F4  = 8'hF4;
	localparam logic [BYTE_W-1:0] ST_UNDEF_F5  = 8'hF5;
	localparam logic [BYTE_W-1:0] ST_TUNE_REQ  = 8'hF6;
	localparam logic [BYTE_W-1:0] ST_EOX       = 8'hF7;
	localparam logic [BYTE_W-1:0] ST_UNDEF_F9  = 8'hF9;
	localparam logic [BYTE_W-1:0] ST_UNDEF_FD  = 8'hFD;

	localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
	localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
	localparam logic [3:0] HI_SYSTEM      = 4'hF;
	localparam logic [4:0] HI_REALTIME    = 5'b11111;

	typedef enum logic [1:0] {
		LEN_SKIP,
		LEN_ONE,
		LEN_TWO
	} msg_len_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    midi_byte;
		logic [ARRIVAL_W-1:0] arrival_ns;
	} stream_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] status_byte;
		logic [DATA_W-1:0] first_data;
		logic [DATA_W-1:0] second_data;
		logic [TIME_W-1:0] time_units;
	} event_item_t;

	function automatic msg_len_t msg_len(input logic [BYTE_W-1:0] st);
		msg_len_t len;
		len = LEN_SKIP;
		if (st[7:4] != HI_SYSTEM) begin
			if (st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CHAN_PRESS) begin
				len = LEN_ONE;
			end else begin
				len = LEN_TWO;
			end
		end else begin
			unique case (st) inside
				ST_MTC, ST_SONG_SEL: len = LEN_ONE;
				ST_SONG_POS:         len = LEN_TWO;
				default:             len = LEN_SKIP;
			endcase
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/msmp_if.sv =====
// Valid/ready channel interfaces for the MIDI short message parser:
// byte stream in, message events out. Depends on msmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface msmp_stream_if;
	logic                   valid;
	logic                   ready;
	msmp_pkg::stream_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface msmp_event_if;
	logic                  valid;
	logic                  ready;
	msmp_pkg::event_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== hdl/midi_short_message_parser.sv =====
// MIDI short message parser with running status: top level.
// Depends on msmp_pkg and msmp_if (msmp_stream_if, msmp_event_if).
//
//   channel  dir  handshake        payload
//   stream   in   valid/ready      midi_byte, arrival_ns
//   events   out  valid/ready      status_byte, first_data, second_data, time_units
//   apb      in   psel/penable     delay_ns at word 0
//
// Two register stages: the input register (delay added there) and the event register.
// One byte per cycle unless the output stalls; input register feeds event register.
// Parser state updates when a byte leaves the input register.
// An event stalled at the output holds the input register; stream.ready drops only then.
// arst_n clears running/pending status, both valid flags and restores delay_ns.
`timescale 1ns / 1ps
`default_nettype none

module midi_short_message_parser (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [msmp_pkg::PADDR_W-1:0]       paddr,
	input  wire  [msmp_pkg::PDATA_W-1:0]       pwdata,
	output logic [msmp_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready,
	msmp_stream_if.sink                        stream,
	msmp_event_if.source                       events
);

	logic [msmp_pkg::DELAY_W-1:0] delay_q;

	logic                          valid_s1;
	logic [msmp_pkg::BYTE_W-1:0]   byte_s1;
	logic [msmp_pkg::TIME_W-1:0]   time_s1;
	logic [msmp_pkg::SUM_W-1:0]    stamp_sum;

	logic [msmp_pkg::BYTE_W-1:0]   running_q;
	logic [msmp_pkg::BYTE_W-1:0]   pending_q;
	logic [msmp_pkg::DATA_W-1:0]   held_q;
	logic                          count_q;
	logic [msmp_pkg::TIME_W-1:0]   mtime_q;

	logic [msmp_pkg::BYTE_W-1:0]   running_d;
	logic [msmp_pkg::BYTE_W-1:0]   pending_d;
	logic [msmp_pkg::DATA_W-1:0]   held_d;
	logic                          count_d;
	logic [msmp_pkg::TIME_W-1:0]   mtime_d;

	logic                          emit;
	msmp_pkg::event_item_t         result;
	logic                          out_valid_q;
	msmp_pkg::event_item_t         out_item_q;
	logic                          out_free;
	logic                          consume;

	// configuration port
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[msmp_pkg::PADDR_W-1] == msmp_pkg::REG_DELAY) begin
			prdata = delay_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= msmp_pkg::DELAY_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[msmp_pkg::PADDR_W-1] == msmp_pkg::REG_DELAY) begin
			delay_q <= pwdata;
		end
	end

	// handshake
	assign out_free     = !out_valid_q || events.ready;
	assign consume      = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || out_free;

	assign stamp_sum = stream.item.arrival_ns[msmp_pkg::SUM_W-1:0]
		+ msmp_pkg::SUM_W'(delay_q);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.item.midi_byte;
			time_s1 <= stamp_sum[msmp_pkg::SUM_W-1:msmp_pkg::TIME_LSB];
		end
	end

	// byte decode
	always_comb begin
		logic [msmp_pkg::BYTE_W-1:0] eff_status;
		logic [msmp_pkg::DATA_W-1:0] eff_held;
		logic                        eff_count;
		logic [msmp_pkg::TIME_W-1:0] eff_time;
		logic                        have_msg;

		running_d = running_q;
		pending_d = pending_q;
		held_d    = held_q;
		count_d   = count_q;
		mtime_d   = mtime_q;
		emit      = 1'b0;
		result    = '{status_byte: byte_s1, first_data: '0, second_data: '0,
			time_units: time_s1};
		eff_status = pending_q;
		eff_held   = held_q;
		eff_count  = count_q;
		eff_time   = mtime_q;
		have_msg   = 1'b1;

		if (byte_s1[7:3] == msmp_pkg::HI_REALTIME) begin
			if (byte_s1 == msmp_pkg::ST_UNDEF_F9 || byte_s1 == msmp_pkg::ST_UNDEF_FD) begin
				pending_d = msmp_pkg::ST_NONE;
				count_d   = 1'b0;
			end else begin
				emit = 1'b1;
			end
		end else if (byte_s1[7:4] == msmp_pkg::HI_SYSTEM) begin
			running_d = msmp_pkg::ST_NONE;
			pending_d = msmp_pkg::ST_NONE;
			count_d   = 1'b0;
			if (byte_s1 == msmp_pkg::ST_TUNE_REQ) begin
				emit = 1'b1;
			end else if (byte_s1 != msmp_pkg::ST_EOX) begin
				pending_d = byte_s1;
				mtime_d   = time_s1;
			end
		end else if (byte_s1[7]) begin
			running_d = byte_s1;
			pending_d = byte_s1;
			count_d   = 1'b0;
			mtime_d   = time_s1;
		end else begin
			if (pending_q == msmp_pkg::ST_NONE) begin
				if (running_q == msmp_pkg::ST_NONE) begin
					have_msg = 1'b0;
				end else begin
					eff_status = running_q;
					eff_count  = 1'b0;
					eff_time   = time_s1;
					pending_d  = running_q;
					count_d    = 1'b0;
					mtime_d    = time_s1;
				end
			end
			if (have_msg) begin
				result.status_byte = eff_status;
				result.time_units  = eff_time;
				unique case (msmp_pkg::msg_len(eff_status))
					msmp_pkg::LEN_ONE: begin
						emit              = 1'b1;
						result.first_data = byte_s1[msmp_pkg::DATA_W-1:0];
						pending_d         = msmp_pkg::ST_NONE;
						count_d           = 1'b0;
					end
					msmp_pkg::LEN_TWO: begin
						if (!eff_count) begin
							held_d  = byte_s1[msmp_pkg::DATA_W-1:0];
							count_d = 1'b1;
						end else begin
							emit               = 1'b1;
							result.first_data  = eff_held;
							result.second_data = byte_s1[msmp_pkg::DATA_W-1:0];
							pending_d          = msmp_pkg::ST_NONE;
							count_d            = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= msmp_pkg::ST_NONE;
			pending_q <= msmp_pkg::ST_NONE;
			count_q   <= 1'b0;
		end else if (consume) begin
			running_q <= running_d;
			pending_q <= pending_d;
			count_q   <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			held_q  <= held_d;
			mtime_q <= mtime_d;
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume) begin
			out_valid_q <= emit;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && emit) begin
			out_item_q <= result;
		end
	end

	assign events.valid = out_valid_q;
	assign events.item  = out_item_q;

endmodule

`default_nettype wire

// ===== hdl/msmp_checker.sv =====
// Port-level checker for the MIDI short message parser, bound to the top level.
// Depends on msmp_pkg and midi_short_message_parser_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "midi_short_message_parser_assert.svh"

module msmp_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             evt_valid,
	input wire                             evt_ready,
	input wire [msmp_pkg::BYTE_W-1:0]      evt_status,
	input wire [msmp_pkg::DATA_W-1:0]      evt_first,
	input wire [msmp_pkg::DATA_W-1:0]      evt_second,
	input wire [msmp_pkg::TIME_W-1:0]      evt_time
);

	`MSMP_ASSERT_NEXT(a_evt_hold, evt_valid && !evt_ready, evt_valid, "event dropped while stalled")
	`MSMP_ASSERT_NEXT(a_evt_stable, evt_valid && !evt_ready, $stable(evt_status) && $stable(evt_first) && $stable(evt_second) && $stable(evt_time), "event payload changed while stalled")
	`MSMP_ASSERT_NOW(a_evt_status, evt_valid, evt_status[7] && evt_status != msmp_pkg::ST_SYSEX && evt_status != msmp_pkg::ST_UNDEF_F4 && evt_status != msmp_pkg::ST_UNDEF_F5 && evt_status != msmp_pkg::ST_EOX && evt_status != msmp_pkg::ST_UNDEF_F9 && evt_status != msmp_pkg::ST_UNDEF_FD, "event with a status that never completes")
	`MSMP_ASSERT_NOW(a_evt_alone, evt_valid && (evt_status[7:3] == msmp_pkg::HI_REALTIME || evt_status == msmp_pkg::ST_TUNE_REQ), evt_first == '0 && evt_second == '0, "single-byte event carries data")
	`MSMP_ASSERT_NOW(a_evt_one_byte, evt_valid && (evt_status[7:4] == msmp_pkg::HI_PROG_CHANGE || evt_status[7:4] == msmp_pkg::HI_CHAN_PRESS || evt_status == msmp_pkg::ST_MTC || evt_status == msmp_pkg::ST_SONG_SEL), evt_second == '0, "one-data-byte event carries second data")

endmodule

bind midi_short_message_parser msmp_checker u_msmp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.evt_valid  (events.valid),
	.evt_ready  (events.ready),
	.evt_status (events.item.status_byte),
	.evt_first  (events.item.first_data),
	.evt_second (events.item.second_data),
	.evt_time   (events.item.time_units)
);

`default_nettype wire

// ===== tb/msmp_event_check.sv =====
// Checker for the MIDI short message parser: follows every stream transaction and
// every APB access to delay_ns, predicts the message events and compares them in order.
// Depends on msmp_pkg and msmp_if; hands its failure count to the tb top.
`timescale 1ns / 1ps

module msmp_event_check (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [msmp_pkg::PADDR_W-1:0] paddr,
	input  wire  [msmp_pkg::PDATA_W-1:0] pwdata,
	input  wire  [msmp_pkg::PDATA_W-1:0] prdata,
	input  wire                          pready,
	msmp_stream_if                       stream,
	msmp_event_if                        events,
	output int unsigned                  outstanding,
	output int unsigned                  fail_count
);
	import msmp_pkg::*;

	localparam int unsigned STAMP_W = 64;

	logic [DELAY_W-1:0] delay_ns;
	logic [BYTE_W-1:0]  running_st;
	logic [BYTE_W-1:0]  pending_st;
	logic [DATA_W-1:0]  held_d1;
	logic               has_d1;
	logic [STAMP_W-1:0] msg_stamp;
	event_item_t        expected_events[$];

	function automatic void clear_pending();
		pending_st = ST_NONE;
		held_d1 = '0;
		has_d1 = 1'b0;
	endfunction

	function automatic msg_len_t data_bytes_for(input logic [BYTE_W-1:0] st);
		if (st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CHAN_PRESS
				|| st == ST_MTC || st == ST_SONG_SEL) begin
			return LEN_ONE;
		end
		if (st[7:4] != HI_SYSTEM || st == ST_SONG_POS) begin
			return LEN_TWO;
		end
		return LEN_SKIP;
	endfunction

	function automatic event_item_t make_event(input logic [BYTE_W-1:0] st,
			input logic [DATA_W-1:0] d1, input logic [DATA_W-1:0] d2,
			input logic [STAMP_W-1:0] stamp);
		event_item_t e;
		e.status_byte = st;
		e.first_data = d1;
		e.second_data = d2;
		e.time_units = stamp[TIME_LSB +: TIME_W];
		return e;
	endfunction

	task automatic absorb_byte(input stream_item_t it);
		logic [BYTE_W-1:0]  b;
		logic [STAMP_W-1:0] stamp;
		b = it.midi_byte;
		stamp = {1'b0, it.arrival_ns} + STAMP_W'(delay_ns);
		if (b[7:3] == HI_REALTIME) begin
			if (b == ST_UNDEF_F9 || b == ST_UNDEF_FD) begin
				clear_pending();
			end else begin
				expected_events.push_back(make_event(b, '0, '0, stamp));
			end
		end else if (b[7:4] == HI_SYSTEM) begin
			running_st = ST_NONE;
			clear_pending();
			if (b == ST_TUNE_REQ) begin
				expected_events.push_back(make_event(b, '0, '0, stamp));
			end else if (b != ST_EOX) begin
				pending_st = b;
				msg_stamp = stamp;
			end
		end else if (b[7]) begin
			running_st = b;
			clear_pending();
			pending_st = b;
			msg_stamp = stamp;
		end else begin
			if (pending_st == ST_NONE && running_st != ST_NONE) begin
				clear_pending();
				pending_st = running_st;
				msg_stamp = stamp;
			end
			if (pending_st != ST_NONE) begin
				case (data_bytes_for(pending_st))
					LEN_ONE: begin
						expected_events.push_back(make_event(pending_st, b[DATA_W-1:0], '0,
							msg_stamp));
						clear_pending();
					end
					LEN_TWO: begin
						if (!has_d1) begin
							held_d1 = b[DATA_W-1:0];
							has_d1 = 1'b1;
						end else begin
							expected_events.push_back(make_event(pending_st, held_d1,
								b[DATA_W-1:0], msg_stamp));
							clear_pending();
						end
					end
					default: begin
					end
				endcase
			end
		end
	endtask

	task automatic check_event(input event_item_t got);
		event_item_t want;
		if (expected_events.size() == 0) begin
			$error("unexpected event: status_byte %0h first_data %0h second_data %0h",
				got.status_byte, got.first_data, got.second_data);
			fail_count++;
		end else begin
			want = expected_events.pop_front();
			if (got.status_byte !== want.status_byte) begin
				$error("status_byte expected %0h actual %0h", want.status_byte, got.status_byte);
				fail_count++;
			end
			if (got.first_data !== want.first_data) begin
				$error("first_data expected %0h actual %0h", want.first_data, got.first_data);
				fail_count++;
			end
			if (got.second_data !== want.second_data) begin
				$error("second_data expected %0h actual %0h", want.second_data, got.second_data);
				fail_count++;
			end
			if (got.time_units !== want.time_units) begin
				$error("time_units expected %0h actual %0h", want.time_units, got.time_units);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ns = DELAY_RESET;
			running_st = ST_NONE;
			clear_pending();
			msg_stamp = '0;
			expected_events.delete();
			outstanding = 0;
		end else begin
			if (events.valid && events.ready) begin
				check_event(events.item);
			end
			if (stream.valid && stream.ready) begin
				absorb_byte(stream.item);
			end
			if (psel && penable && pready && paddr[PADDR_W-1] == REG_DELAY) begin
				if (pwrite) begin
					delay_ns = pwdata[DELAY_W-1:0];
				end else if (prdata[DELAY_W-1:0] !== delay_ns) begin
					$error("delay_ns expected %0h actual %0h", delay_ns, prdata[DELAY_W-1:0]);
					fail_count++;
				end
			end
			outstanding = expected_events.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the MIDI short message parser: clock, reset, byte
// stream, event sink and APB stimulus, plus the verdict.
// Depends on msmp_pkg, msmp_if, msmp_event_check and the parser RTL.
`timescale 1ns / 1ps

module tb;
	import msmp_pkg::*;

	localparam logic [BYTE_W-1:0] CHAN_FIRST  = 8'h80;
	localparam logic [BYTE_W-1:0] CHAN_LAST   = 8'hEF;
	localparam logic [BYTE_W-1:0] NOTE_ON_CH0 = 8'h90;
	localparam logic [BYTE_W-1:0] CTRL_CH0    = 8'hB0;
	localparam logic [BYTE_W-1:0] PROG_CH5    = 8'hC5;
	localparam logic [BYTE_W-1:0] BEND_CH3    = 8'hE3;
	localparam logic [BYTE_W-1:0] RT_FIRST    = 8'hF8;
	localparam logic [BYTE_W-1:0] RT_LAST     = 8'hFF;
	localparam logic [BYTE_W-1:0] DATA_MAX    = 8'h7F;
	localparam logic [PADDR_W-1:0] DELAY_ADDR = PADDR_W'(REG_DELAY) << 2;
	localparam int unsigned PHASE_BYTES = 112;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES = 4;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int unsigned        outstanding;
	int unsigned        fail_count;

	bit                 src_steady;
	bit                 snk_steady;
	bit                 hold_req;
	int unsigned        bytes_sent;
	logic [ARRIVAL_W-1:0] clock_ns;

	msmp_stream_if stream();
	msmp_event_if  events();

	midi_short_message_parser u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.stream  (stream),
		.events  (events)
	);

	msmp_event_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.stream      (stream),
		.events      (events),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("midi_short_message_parser regression: fail");
		$finish;
	end

	// event sink: random back-pressure, plus a long hold-off on request
	initial begin : event_sink
		int unsigned hold_left;
		hold_left = 0;
		events.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				events.ready = 1'b0;
				hold_left--;
			end else begin
				events.ready = snk_steady || ($urandom_range(99) >= 32);
			end
		end
	end

	function automatic logic [ARRIVAL_W-1:0] next_arrival();
		logic [ARRIVAL_W-1:0] t;
		case ($urandom_range(9))
			0: t = ARRIVAL_W'($urandom_range(1023));
			1: t = '1 - ARRIVAL_W'($urandom_range(1023));
			2, 3: t = ARRIVAL_W'({$urandom, $urandom});
			default: begin
				clock_ns += ARRIVAL_W'($urandom_range(400000));
				t = clock_ns;
			end
		endcase
		return t;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [ARRIVAL_W-1:0] t);
		while (!src_steady && $urandom_range(99) < 32) begin
			stream.valid = 1'b0;
			@(negedge clk);
		end
		stream.valid = 1'b1;
		stream.item.midi_byte = b;
		stream.item.arrival_ns = t;
		do @(posedge clk); while (!stream.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// data byte, sometimes preceded by a byte from the realtime range (F8 to FF) inside the message
	task automatic send_data(input logic [BYTE_W-1:0] d);
		if ($urandom_range(99) < 8) begin
			send_byte(BYTE_W'($urandom_range(RT_FIRST, RT_LAST)), next_arrival());
		end
		send_byte(d, next_arrival());
	endtask

	task automatic send_phrase();
		int unsigned pick;
		int unsigned n;
		logic [BYTE_W-1:0] st;
		pick = $urandom_range(99);
		if (pick < 35) begin
			st = BYTE_W'($urandom_range(CHAN_FIRST, CHAN_LAST));
			n = (st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CHAN_PRESS) ? 1 : 2;
			send_byte(st, next_arrival());
			if ($urandom_range(99) < 10) begin
				n = $urandom_range(0, n - 1);
			end else if ($urandom_range(99) < 50) begin
				n = n * $urandom_range(2, 4);
			end
			repeat (n) send_data(BYTE_W'($urandom_range(DATA_MAX)));
		end else if (pick < 50) begin
			repeat ($urandom_range(1, 2)) send_data(BYTE_W'($urandom_range(DATA_MAX)));
		end else if (pick < 62) begin
			case ($urandom_range(2))
				0: st = ST_MTC;
				1: st = ST_SONG_POS;
				default: st = ST_SONG_SEL;
			endcase
			send_byte(st, next_arrival());
			repeat (st == ST_SONG_POS ? 2 : 1) send_data(BYTE_W'($urandom_range(DATA_MAX)));
		end else if (pick < 70) begin
			send_byte(ST_SYSEX, next_arrival());
			repeat ($urandom_range(4)) send_data(BYTE_W'($urandom_range(DATA_MAX)));
			if ($urandom_range(99) < 80) begin
				send_byte(ST_EOX, next_arrival());
			end
		end else if (pick < 75) begin
			send_byte($urandom_range(1) ? ST_UNDEF_F4 : ST_UNDEF_F5, next_arrival());
			repeat ($urandom_range(2)) send_data(BYTE_W'($urandom_range(DATA_MAX)));
		end else if (pick < 80) begin
			send_byte(ST_TUNE_REQ, next_arrival());
		end else if (pick < 88) begin
			send_byte(BYTE_W'($urandom_range(RT_FIRST, RT_LAST)), next_arrival());
		end else begin
			send_byte(BYTE_W'($urandom_range(255)), next_arrival());
		end
	endtask

	task automatic send_phrases(input int unsigned count);
		int unsigned start;
		start = bytes_sent;
		while (bytes_sent - start < count) send_phrase();
	endtask

	task automatic apb_access(input logic write, input logic [PDATA_W-1:0] value);
		paddr = DELAY_ADDR;
		pwdata = value;
		pwrite = write;
		psel = 1'b1;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// hold the stream until every expected event is out and the pipe is empty
	task automatic settle();
		stream.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		logic [BYTE_W-1:0] opening [$];
		logic [PDATA_W-1:0] delays [4];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stream.valid = 1'b0;
		stream.item = '0;
		src_steady = 1'b0;
		snk_steady = 1'b0;
		hold_req = 1'b0;
		bytes_sent = 0;
		clock_ns = ARRIVAL_W'({$urandom, $urandom});
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		apb_access(1'b0, '0);
		opening = '{8'h00, NOTE_ON_CH0, 8'h3C, DATA_MAX, CTRL_CH0, 8'h07, RT_FIRST, 8'h40,
			BEND_CH3, 8'h01, ST_UNDEF_FD, 8'h10, 8'h20, PROG_CH5, DATA_MAX,
			ST_MTC, 8'h55, ST_SONG_POS, 8'h01, 8'h02, ST_SONG_SEL, DATA_MAX, ST_TUNE_REQ,
			ST_SYSEX, 8'h11, ST_EOX, ST_UNDEF_F4, 8'h12, ST_UNDEF_F5, ST_UNDEF_F9, RT_LAST,
			8'h42};
		foreach (opening[i]) begin
			case (i % 3)
				0: send_byte(opening[i], '0);
				1: send_byte(opening[i], '1);
				default: send_byte(opening[i], next_arrival());
			endcase
		end

		delays = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1023};
		foreach (delays[p]) begin
			settle();
			apb_access(1'b1, delays[p]);
			apb_access(1'b0, '0);
			if (p == 1) begin
				src_steady = 1'b1;
				snk_steady = 1'b1;
				send_phrases(50);
				src_steady = 1'b0;
				snk_steady = 1'b0;
				send_phrases(PHASE_BYTES - 50);
			end else if (p == 2) begin
				hold_req = 1'b1;
				src_steady = 1'b1;
				send_phrases(40);
				src_steady = 1'b0;
				send_phrases(PHASE_BYTES - 40);
			end else begin
				send_phrases(PHASE_BYTES);
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0) begin
			$display("midi_short_message_parser regression: pass");
		end else begin
			$display("midi_short_message_parser regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/msmp_pkg.sv
hdl/msmp_if.sv
hdl/midi_short_message_parser.sv
hdl/msmp_checker.sv
tb/msmp_event_check.sv
tb/tb.sv
